// ----- hdl/spq_pkg.sv -----
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int VALUE_W = 32;
    localparam int PRIO_W = 8;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] STS_VALUE = 3'd0;
    localparam logic [2:0] STS_ENQUEUED = 3'd1;
    localparam logic [2:0] STS_UNDERFLOW = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STS_FULL = 3'd4;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                    op;
        logic [PRIO_W-1:0]           key;
        logic signed [VALUE_W-1:0]   value;
    } cell_cmd_t;

    typedef struct packed {
        logic                        occ;
        logic signed [VALUE_W-1:0]   value;
        logic [PRIO_W-1:0]           prio;
    } cell_data_t;

endpackage

// ----- hdl/spq_if.sv -----
interface spq_req_if;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic signed [31:0]  item_value;
    logic [7:0]          item_priority;

    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  out_value;
    logic [2:0]          status;
    logic                last;

    modport source (output valid, out_value, status, last, input ready);
    modport sink (input valid, out_value, status, last, output ready);
endinterface

// ----- hdl/spq_cell.sv -----
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::cell_data_t left,
    input  logic               left_keep,
    input  logic               left_match,
    input  spq_pkg::cell_data_t right,
    input  logic               right_match,
    output spq_pkg::cell_data_t q,
    output logic               keep,
    output logic               match,
    output logic               hit,
    output logic               more
);
    import spq_pkg::*;

    logic                      occ_reg, occ_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [PRIO_W-1:0]         prio_reg, prio_next;
    logic                      at_or_past;

    assign q          = '{occ: occ_reg, value: value_reg, prio: prio_reg};
    assign keep       = occ_reg && (prio_reg <= cmd.key);
    assign match      = occ_reg && (prio_reg == cmd.key);
    // list is sorted, so every entry from the first match onward has prio >= key
    assign at_or_past = occ_reg && (prio_reg >= cmd.key);
    assign hit        = match && !left_match;
    assign more       = hit && right_match;

    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        occ_next   = 1'b1;
                        value_next = cmd.value;
                        prio_next  = cmd.key;
                    end
                    else
                    begin
                        occ_next   = left.occ;
                        value_next = left.value;
                        prio_next  = left.prio;
                    end
                end
            end
            CELL_SHIFT:
            begin
                occ_next   = right.occ;
                value_next = right.value;
                prio_next  = right.prio;
            end
            CELL_REMOVE:
            begin
                if (at_or_past)
                begin
                    occ_next   = right.occ;
                    value_next = right.value;
                    prio_next  = right.prio;
                end
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

// ----- hdl/stable_priority_queue_top.sv -----
// Stable priority queue, kept sorted by ascending priority number in a chain
// of DEPTH cells. Entries of equal priority leave in arrival order.
//
// Channels: req carries one request (command, item_value, item_priority);
// rsp carries results (out_value, status, last), last marking the final
// result of a request. Both use valid/ready.
//
// Flow: a result is registered and shows on rsp in the cycle after its
// request is accepted. After an enqueue or dequeue-head a new request may
// follow every cycle while rsp keeps up. Remove-by-priority emits one
// result per cycle while rsp keeps up and occupies the block until its
// last matching entry is out; req.ready stays low meanwhile. Every cell
// shifts, holds or loads from its two neighbors.
//
// Stall: while rsp.ready is low and a result waits, req.ready drops and the
// cells hold. Reset empties the queue and clears the output valid flag.
module stable_priority_queue_top (
    input  logic clk,
    input  logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [PRIO_W-1:0]         key_reg, key_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [2:0]                status_reg, status_next;
    logic                      last_reg, last_next;

    cell_cmd_t                 cmd;
    cell_data_t                cell_q [DEPTH];
    logic [DEPTH-1:0]          keep_vec, match_vec, hit_vec, more_vec, occ_vec;
    logic signed [VALUE_W-1:0] hit_value;
    logic                      any_hit, any_more;
    logic                      out_free, req_fire;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.status    = status_reg;
    assign rsp.last      = last_reg;

    // Chain of cells; boundaries: left of cell 0 always keeps, right of last is empty
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        cell_data_t left_d, right_d;
        logic       left_k, left_m, right_m;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
            assign left_k = 1'b1;
            assign left_m = 1'b0;
        end
        else
        begin : g_inner_l
            assign left_d = cell_q[g-1];
            assign left_k = keep_vec[g-1];
            assign left_m = match_vec[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
            assign right_m = 1'b0;
        end
        else
        begin : g_inner_r
            assign right_d = cell_q[g+1];
            assign right_m = match_vec[g+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left        (left_d),
            .left_keep   (left_k),
            .left_match  (left_m),
            .right       (right_d),
            .right_match (right_m),
            .q           (cell_q[g]),
            .keep        (keep_vec[g]),
            .match       (match_vec[g]),
            .hit         (hit_vec[g]),
            .more        (more_vec[g])
        );

        assign occ_vec[g] = cell_q[g].occ;
    end

    // Pick the value of the first matching cell (at most one hit)
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_value = hit_value | (cell_q[i].value & {VALUE_W{hit_vec[i]}});
        end
    end

    assign any_hit  = |hit_vec;
    assign any_more = |more_vec;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        cmd.op         = CELL_HOLD;
        cmd.key        = (state_reg == ST_DRAIN) ? key_reg : req.item_priority;
        cmd.value      = req.item_value;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    last_next      = 1'b1;
                    case (req.command)
                        CMD_ENQUEUE:
                        begin
                            if (occ_vec[DEPTH-1])
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                cmd.op      = CELL_INSERT;
                                status_next = STS_ENQUEUED;
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            if (!occ_vec[0])
                            begin
                                status_next = STS_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.op         = CELL_SHIFT;
                                status_next    = STS_VALUE;
                                out_value_next = cell_q[0].value;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!occ_vec[0])
                            begin
                                status_next = STS_UNDERFLOW;
                            end
                            else if (!any_hit)
                            begin
                                status_next = STS_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.op         = CELL_REMOVE;
                                status_next    = STS_VALUE;
                                out_value_next = hit_value;
                                last_next      = !any_more;
                                key_next       = req.item_priority;
                                if (any_more)
                                begin
                                    state_next = ST_DRAIN;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code: drop the request, no result
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.op         = CELL_REMOVE;
                    out_valid_next = 1'b1;
                    out_value_next = hit_value;
                    status_next    = STS_VALUE;
                    last_next      = !any_more;
                    if (!any_more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

`ifndef SYNTHESIS
    // occupied cells always form a prefix of the chain
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, occ_vec} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("occupied cells are not a prefix");

    // while draining a removal, a matching entry must still be present
    a_drain_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> any_hit)
        else $error("drain state without a matching entry");

    // at most one cell sees itself as the first match
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one first-match cell");

    // every result other than a value out ends its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != STS_VALUE) |-> rsp.last)
        else $error("non-value result without last");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import spq_pkg::*;

    // Command code the block does not use: it must be swallowed silently
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int TOTAL_REQUESTS = 170;
    localparam int QUIET_TAIL = 25;     // last requests run without idling
    localparam int HOLD_AT = 100;       // request count that starts the long rsp hold
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [2:0]                status;
        logic                      last;
    } result_t;

    // One row of the directed table. A typed row carries its own single result;
    // reps repeats the row with the value stepping up by one each time.
    typedef struct {
        logic [1:0]                cmd;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        int                        reps;
        bit                        typed;
        logic [2:0]                want_status;
        logic signed [VALUE_W-1:0] want_value;
    } stim_row_t;

    localparam int NUM_ROWS = 12;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // empty queue: both dequeue forms underflow
        '{CMD_DEQUEUE, 32'sh0000_0000, 8'd0,   1,  1'b1, STS_UNDERFLOW, 32'sh0},
        '{CMD_REMOVE,  32'sh0000_0000, 8'd5,   1,  1'b1, STS_UNDERFLOW, 32'sh0},
        // unused code: no result at all
        '{CMD_UNUSED,  32'sh1234_5678, 8'hA5,  1,  1'b0, STS_VALUE,     32'sh0},
        // extremes of value and priority, then fill with one shared priority
        '{CMD_ENQUEUE, 32'sh7FFF_FFFF, 8'd255, 1,  1'b1, STS_ENQUEUED,  32'sh0},
        '{CMD_ENQUEUE, 32'sh8000_0000, 8'd0,   1,  1'b1, STS_ENQUEUED,  32'sh0},
        '{CMD_ENQUEUE, 32'sh0000_1000, 8'd3,   14, 1'b1, STS_ENQUEUED,  32'sh0},
        // full: drop
        '{CMD_ENQUEUE, 32'shFFFF_FFFF, 8'd1,   1,  1'b1, STS_FULL,      32'sh0},
        // no entry with this key
        '{CMD_REMOVE,  32'shFFFF_FFFF, 8'd9,   1,  1'b1, STS_NOT_FOUND, 32'sh0},
        // fourteen ties leave in arrival order
        '{CMD_REMOVE,  32'sh0000_0000, 8'd3,   1,  1'b0, STS_VALUE,     32'sh0},
        // key matches the head entry
        '{CMD_REMOVE,  32'sh0000_0000, 8'd0,   1,  1'b1, STS_VALUE,     32'sh8000_0000},
        // value field is ignored by dequeue
        '{CMD_DEQUEUE, 32'sh5A5A_5A5A, 8'd255, 1,  1'b1, STS_VALUE,     32'sh7FFF_FFFF},
        '{CMD_DEQUEUE, 32'sh0000_0000, 8'd0,   1,  1'b1, STS_UNDERFLOW, 32'sh0}
    };

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Sorted contents the block should hold, lowest priority number first
    logic signed [VALUE_W-1:0] sorted_values [DEPTH];
    logic [PRIO_W-1:0]         sorted_prios [DEPTH];
    int                        sorted_count = 0;

    result_t step_results [$];      // results caused by the request just accepted
    result_t pending_results [$];   // results still owed by the block

    int  mismatches = 0;
    int  counted_requests = 0;      // accepted requests with a real command
    bit  quiet_tail = 1'b0;         // drop all idling on both channels

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic log_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Apply one request to the sorted contents and collect the results it causes
    function automatic void sorted_queue_apply(input logic [1:0] cmd,
                                               input logic signed [VALUE_W-1:0] val,
                                               input logic [PRIO_W-1:0] prio);
        int pos;
        int keep;
        int hits;
        int n;
        logic signed [VALUE_W-1:0] head;
        step_results.delete();
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (sorted_count >= DEPTH)
                begin
                    step_results.push_back('{'0, STS_FULL, 1'b1});
                end
                else
                begin
                    // place after every entry of equal priority
                    pos = 0;
                    while (pos < sorted_count && sorted_prios[pos] <= prio)
                        pos++;
                    for (int i = sorted_count; i > pos; i--)
                    begin
                        sorted_values[i] = sorted_values[i-1];
                        sorted_prios[i] = sorted_prios[i-1];
                    end
                    sorted_values[pos] = val;
                    sorted_prios[pos] = prio;
                    sorted_count++;
                    step_results.push_back('{'0, STS_ENQUEUED, 1'b1});
                end
            end
            CMD_DEQUEUE:
            begin
                if (sorted_count == 0)
                begin
                    step_results.push_back('{'0, STS_UNDERFLOW, 1'b1});
                end
                else
                begin
                    head = sorted_values[0];
                    for (int i = 1; i < sorted_count; i++)
                    begin
                        sorted_values[i-1] = sorted_values[i];
                        sorted_prios[i-1] = sorted_prios[i];
                    end
                    sorted_count--;
                    step_results.push_back('{head, STS_VALUE, 1'b1});
                end
            end
            CMD_REMOVE:
            begin
                if (sorted_count == 0)
                begin
                    step_results.push_back('{'0, STS_UNDERFLOW, 1'b1});
                end
                else
                begin
                    hits = 0;
                    for (int i = 0; i < sorted_count; i++)
                        if (sorted_prios[i] == prio)
                            hits++;
                    keep = 0;
                    n = 0;
                    for (int i = 0; i < sorted_count; i++)
                    begin
                        if (sorted_prios[i] == prio)
                        begin
                            n++;
                            step_results.push_back('{sorted_values[i], STS_VALUE, n == hits});
                        end
                        else
                        begin
                            sorted_values[keep] = sorted_values[i];
                            sorted_prios[keep] = sorted_prios[i];
                            keep++;
                        end
                    end
                    sorted_count = keep;
                    if (hits == 0)
                        step_results.push_back('{'0, STS_NOT_FOUND, 1'b1});
                end
            end
            default:
            begin
                // unused code: nothing happens
            end
        endcase
    endfunction

    // Mostly a narrow band so that ties and multi-entry removals are common
    function automatic logic [PRIO_W-1:0] pick_priority();
        if ($urandom_range(0, 5) == 0)
            return PRIO_W'($urandom_range(0, 255));
        return PRIO_W'($urandom_range(0, 7));
    endfunction

    // Removal key: usually one that is present, sometimes anything
    function automatic logic [PRIO_W-1:0] pick_key();
        if (sorted_count > 0 && $urandom_range(0, 3) != 0)
            return sorted_prios[$urandom_range(0, sorted_count - 1)];
        return pick_priority();
    endfunction

    // Offer one request, hold it until accepted, then book its results.
    // A typed request books the given result instead of the predicted one.
    task automatic offer(input logic [1:0] cmd,
                         input logic signed [VALUE_W-1:0] val,
                         input logic [PRIO_W-1:0] prio,
                         input bit typed,
                         input logic [2:0] want_status,
                         input logic signed [VALUE_W-1:0] want_value);
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.item_value <= val;
        req_ch.item_priority <= prio;
        do
            @(posedge clk);
        while (!req_ch.ready);

        sorted_queue_apply(cmd, val, prio);
        if (typed)
            pending_results.push_back('{want_value, want_status, 1'b1});
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);

        if (cmd != CMD_UNUSED)
            counted_requests++;
        quiet_tail = (counted_requests >= TOTAL_REQUESTS - QUIET_TAIL);

        // idle the request side in bursts, landing on any phase of the work
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Request side: directed table, then random episodes
    initial
    begin
        int episode;
        int roll;
        logic [1:0] cmd;
        logic [PRIO_W-1:0] key;

        req_ch.valid <= 1'b0;
        req_ch.command <= CMD_ENQUEUE;
        req_ch.item_value <= '0;
        req_ch.item_priority <= '0;
        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                offer(directed_rows[r].cmd, directed_rows[r].value + k,
                      directed_rows[r].prio, directed_rows[r].typed,
                      directed_rows[r].want_status, directed_rows[r].want_value);

        while (counted_requests < TOTAL_REQUESTS)
        begin
            episode = $urandom_range(0, 9);
            if (episode < 5)
            begin
                // churn: mixed traffic around the current fill level
                repeat ($urandom_range(4, 12))
                begin
                    roll = $urandom_range(0, 19);
                    if (roll < 9)
                        cmd = CMD_ENQUEUE;
                    else if (roll < 14)
                        cmd = CMD_DEQUEUE;
                    else if (roll < 19)
                        cmd = CMD_REMOVE;
                    else
                        cmd = CMD_UNUSED;
                    key = (cmd == CMD_REMOVE) ? pick_key() : pick_priority();
                    offer(cmd, $urandom(), key, 1'b0, STS_VALUE, '0);
                end
            end
            else if (episode < 7)
            begin
                // fill to the brim, push one more, then pull a key out
                while (sorted_count < DEPTH)
                    offer(CMD_ENQUEUE, $urandom(), pick_priority(), 1'b0, STS_VALUE, '0);
                offer(CMD_ENQUEUE, $urandom(), pick_priority(), 1'b0, STS_VALUE, '0);
                offer(CMD_REMOVE, $urandom(), pick_key(), 1'b0, STS_VALUE, '0);
            end
            else if (episode < 9)
            begin
                // drain to empty, then one more on the empty queue
                while (sorted_count > 0)
                begin
                    cmd = ($urandom_range(0, 3) == 0) ? CMD_REMOVE : CMD_DEQUEUE;
                    offer(cmd, $urandom(), pick_key(), 1'b0, STS_VALUE, '0);
                end
                cmd = ($urandom_range(0, 1) == 0) ? CMD_REMOVE : CMD_DEQUEUE;
                offer(cmd, $urandom(), pick_priority(), 1'b0, STS_VALUE, '0);
            end
            else
            begin
                // one key everywhere: a removal then emits a long burst
                key = pick_priority();
                while (sorted_count < DEPTH)
                    offer(CMD_ENQUEUE, $urandom(), key, 1'b0, STS_VALUE, '0);
                offer(CMD_REMOVE, $urandom(), key, 1'b0, STS_VALUE, '0);
            end
        end
        req_ch.valid <= 1'b0;

        // wait for every owed result, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, one long hold to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && counted_requests >= HOLD_AT)
            begin
                // hold off while requests keep coming: the block must stall req
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest one owed
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0b",
                                       rsp_ch.out_value, rsp_ch.status, rsp_ch.last));
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.out_value !== want.value || rsp_ch.status !== want.status ||
                    rsp_ch.last !== want.last)
                    log_mismatch($sformatf({"got value=%0d status=%0d last=%0b, ",
                                            "want value=%0d status=%0d last=%0b"},
                                           rsp_ch.out_value, rsp_ch.status, rsp_ch.last,
                                           want.value, want.status, want.last));
            end
        end
    end

endmodule
